FILE: design/cau_pkg.sv
// Package for the complex arithmetic unit.
// Opcodes and the control struct carried down the pipeline; no dependencies.
package cau_pkg;

  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_MAG = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_zero;
    logic            sat;
  } ctrl_t;

endpackage

FILE: design/cau_if.sv
// Valid/ready channel interfaces of the complex arithmetic unit.
// Depends on nothing; payload width follows DATA_WIDTH.
interface cau_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   opcode;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         div_zero;
  logic                         saturated;

  modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
  modport sink   (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

FILE: design/cau_mult.sv
// Stage 1: six signed products, plus add/subtract with saturation.
// Depends on cau_pkg.
module cau_mult import cau_pkg::*; #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [OP_W-1:0]       opcode,
  input  logic signed [W-1:0]   a_re,
  input  logic signed [W-1:0]   a_im,
  input  logic signed [W-1:0]   b_re,
  input  logic signed [W-1:0]   b_im,
  output logic signed [2*W-1:0] p0_r,
  output logic signed [2*W-1:0] p1_r,
  output logic signed [2*W-1:0] p2_r,
  output logic signed [2*W-1:0] p3_r,
  output logic signed [2*W-1:0] p4_r,
  output logic signed [2*W-1:0] p5_r,
  output logic [W-1:0]          pre_re_r,
  output logic [W-1:0]          pre_im_r,
  output ctrl_t                 ctrl_r
);

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]   x4, x5;
  logic signed [2*W-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt;
  logic [W:0]            s_re, s_im;
  logic [W-1:0]          pre_re_nxt, pre_im_nxt;
  ctrl_t                 ctrl_nxt;

  // magnitude squares a, divide needs |b|^2
  assign x4 = (opcode == OP_MAG) ? a_re : b_re;
  assign x5 = (opcode == OP_MAG) ? a_im : b_im;

  assign p0_nxt = a_re * b_re;
  assign p1_nxt = a_im * b_im;
  assign p2_nxt = a_re * b_im;
  assign p3_nxt = a_im * b_re;
  assign p4_nxt = x4 * x4;
  assign p5_nxt = x5 * x5;

  always_comb begin
    s_re       = '0;
    s_im       = '0;
    pre_re_nxt = '0;
    pre_im_nxt = '0;
    ctrl_nxt   = '{op: opcode, div_zero: 1'b0, sat: 1'b0};
    if (opcode == OP_ADD || opcode == OP_SUB) begin
      if (opcode == OP_ADD) begin
        s_re = {a_re[W-1], a_re} + {b_re[W-1], b_re};
        s_im = {a_im[W-1], a_im} + {b_im[W-1], b_im};
      end else begin
        s_re = {a_re[W-1], a_re} - {b_re[W-1], b_re};
        s_im = {a_im[W-1], a_im} - {b_im[W-1], b_im};
      end
      pre_re_nxt   = (s_re[W] == s_re[W-1]) ? s_re[W-1:0] : (s_re[W] ? MINV : MAXV);
      pre_im_nxt   = (s_im[W] == s_im[W-1]) ? s_im[W-1:0] : (s_im[W] ? MINV : MAXV);
      ctrl_nxt.sat = (s_re[W] != s_re[W-1]) || (s_im[W] != s_im[W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r     <= p0_nxt;
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
      p3_r     <= p3_nxt;
      p4_r     <= p4_nxt;
      p5_r     <= p5_nxt;
      pre_re_r <= pre_re_nxt;
      pre_im_r <= pre_im_nxt;
      ctrl_r   <= ctrl_nxt;
    end
  end

endmodule

FILE: design/cau_sum.sv
// Stage 2: product sums, multiply result with floor and saturation,
// divide numerators and the shared |b|^2 / |a|^2 sum. Depends on cau_pkg.
module cau_sum import cau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [2*W-1:0] p0,
  input  logic signed [2*W-1:0] p1,
  input  logic signed [2*W-1:0] p2,
  input  logic signed [2*W-1:0] p3,
  input  logic signed [2*W-1:0] p4,
  input  logic signed [2*W-1:0] p5,
  input  logic [W-1:0]          pre_re,
  input  logic [W-1:0]          pre_im,
  input  ctrl_t                 ctrl,
  output logic signed [2*W:0]   n_re_r,
  output logic signed [2*W:0]   n_im_r,
  output logic [2*W-1:0]        d_r,
  output logic [W-1:0]          pre_re_r,
  output logic [W-1:0]          pre_im_r,
  output ctrl_t                 ctrl_r
);

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [2*W:0] e0, e1, e2, e3, e4, e5;
  logic signed [2*W:0] m_re, m_im, sh_re, sh_im, dsum;
  logic                fit_re, fit_im;
  logic [W-1:0]        pre_re_nxt, pre_im_nxt;
  ctrl_t               ctrl_nxt;

  assign e0 = {p0[2*W-1], p0};
  assign e1 = {p1[2*W-1], p1};
  assign e2 = {p2[2*W-1], p2};
  assign e3 = {p3[2*W-1], p3};
  assign e4 = {p4[2*W-1], p4};
  assign e5 = {p5[2*W-1], p5};

  assign m_re  = e0 - e1;
  assign m_im  = e2 + e3;
  assign sh_re = m_re >>> F;  // floor
  assign sh_im = m_im >>> F;
  assign fit_re = (&sh_re[2*W:W-1]) || !(|sh_re[2*W:W-1]);
  assign fit_im = (&sh_im[2*W:W-1]) || !(|sh_im[2*W:W-1]);
  assign dsum  = e4 + e5;

  always_comb begin
    pre_re_nxt = pre_re;
    pre_im_nxt = pre_im;
    ctrl_nxt   = ctrl;
    if (ctrl.op == OP_MUL) begin
      pre_re_nxt   = fit_re ? sh_re[W-1:0] : (sh_re[2*W] ? MINV : MAXV);
      pre_im_nxt   = fit_im ? sh_im[W-1:0] : (sh_im[2*W] ? MINV : MAXV);
      ctrl_nxt.sat = !fit_re || !fit_im;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_re_r   <= e0 + e1;
      n_im_r   <= e3 - e2;
      d_r      <= dsum[2*W-1:0];
      pre_re_r <= pre_re_nxt;
      pre_im_r <= pre_im_nxt;
      ctrl_r   <= ctrl_nxt;
    end
  end

endmodule

FILE: design/cau_norm.sv
// Stage 3: numerator sign/magnitude, divider start remainder, zero-divisor
// detect. Depends on cau_pkg.
module cau_norm import cau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [2*W:0] n_re,
  input  logic signed [2*W:0] n_im,
  input  logic [2*W-1:0]      d,
  input  logic [W-1:0]        pre_re,
  input  logic [W-1:0]        pre_im,
  input  ctrl_t               ctrl,
  output logic [2*W-1:0]      rem_re_r,
  output logic [2*W-1:0]      rem_im_r,
  output logic [2*W-1:0]      nmag_re_r,
  output logic [2*W-1:0]      nmag_im_r,
  output logic                neg_re_r,
  output logic                neg_im_r,
  output logic [2*W-1:0]      d_r,
  output logic [W-1:0]        pre_re_r,
  output logic [W-1:0]        pre_im_r,
  output ctrl_t               ctrl_r
);

  logic [2*W:0]   a_re, a_im;
  logic [2*W-1:0] mag_re, mag_im;
  ctrl_t          ctrl_nxt;

  assign a_re   = n_re[2*W] ? (~n_re + 1'b1) : n_re;
  assign a_im   = n_im[2*W] ? (~n_im + 1'b1) : n_im;
  assign mag_re = a_re[2*W-1:0];
  assign mag_im = a_im[2*W-1:0];

  always_comb begin
    ctrl_nxt          = ctrl;
    ctrl_nxt.div_zero = (ctrl.op == OP_DIV) && (d == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_r  <= mag_re >> (W - F);
      rem_im_r  <= mag_im >> (W - F);
      nmag_re_r <= mag_re;
      nmag_im_r <= mag_im;
      neg_re_r  <= n_re[2*W];
      neg_im_r  <= n_im[2*W];
      d_r       <= d;
      pre_re_r  <= pre_re;
      pre_im_r  <= pre_im;
      ctrl_r    <= ctrl_nxt;
    end
  end

endmodule

FILE: design/cau_step.sv
// One pipeline step: one quotient bit for each divider lane and one root
// bit for the square root. Depends on cau_pkg.
module cau_step import cau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16,
  parameter int K = 31
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] rem_re,
  input  logic [2*W-1:0] rem_im,
  input  logic [W-1:0]   q_re,
  input  logic [W-1:0]   q_im,
  input  logic           ovf_re,
  input  logic           ovf_im,
  input  logic [2*W-1:0] nmag_re,
  input  logic [2*W-1:0] nmag_im,
  input  logic           neg_re,
  input  logic           neg_im,
  input  logic [2*W-1:0] d,
  input  logic [W+1:0]   srem,
  input  logic [W-1:0]   sroot,
  input  logic [W-1:0]   pre_re,
  input  logic [W-1:0]   pre_im,
  input  ctrl_t          ctrl,
  output logic [2*W-1:0] rem_re_r,
  output logic [2*W-1:0] rem_im_r,
  output logic [W-1:0]   q_re_r,
  output logic [W-1:0]   q_im_r,
  output logic           ovf_re_r,
  output logic           ovf_im_r,
  output logic [2*W-1:0] nmag_re_r,
  output logic [2*W-1:0] nmag_im_r,
  output logic           neg_re_r,
  output logic           neg_im_r,
  output logic [2*W-1:0] d_r,
  output logic [W+1:0]   srem_r,
  output logic [W-1:0]   sroot_r,
  output logic [W-1:0]   pre_re_r,
  output logic [W-1:0]   pre_im_r,
  output ctrl_t          ctrl_r
);

  localparam bit FIRST   = (K == W - 1);
  localparam bit HAS_BIT = (K >= F);
  localparam int BI      = HAS_BIT ? K - F : 0;

  logic [2*W:0]   t_re, t_im, dx;
  logic           ge_re, ge_im;
  logic [2*W:0]   df_re, df_im;
  logic [W+3:0]   sh, trial, sdf;
  logic           sge;

  // shift in the next dividend bit (zeros below the binary point)
  assign t_re  = {rem_re, HAS_BIT ? nmag_re[BI] : 1'b0};
  assign t_im  = {rem_im, HAS_BIT ? nmag_im[BI] : 1'b0};
  assign dx    = {1'b0, d};
  assign ge_re = t_re >= dx;
  assign ge_im = t_im >= dx;
  assign df_re = t_re - dx;
  assign df_im = t_im - dx;

  // digit-by-digit root, two radicand bits per step
  assign sh    = {srem, d[2*K+1:2*K]};
  assign trial = {2'b00, sroot, 2'b01};
  assign sge   = sh >= trial;
  assign sdf   = sh - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_r  <= ge_re ? df_re[2*W-1:0] : t_re[2*W-1:0];
      rem_im_r  <= ge_im ? df_im[2*W-1:0] : t_im[2*W-1:0];
      q_re_r    <= {q_re[W-2:0], ge_re};
      q_im_r    <= {q_im[W-2:0], ge_im};
      // quotient too wide for W bits when the start remainder reaches d
      ovf_re_r  <= ovf_re || (FIRST && ({1'b0, rem_re} >= dx));
      ovf_im_r  <= ovf_im || (FIRST && ({1'b0, rem_im} >= dx));
      nmag_re_r <= nmag_re;
      nmag_im_r <= nmag_im;
      neg_re_r  <= neg_re;
      neg_im_r  <= neg_im;
      d_r       <= d;
      srem_r    <= sge ? sdf[W+1:0] : sh[W+1:0];
      sroot_r   <= {sroot[W-2:0], sge};
      pre_re_r  <= pre_re;
      pre_im_r  <= pre_im;
      ctrl_r    <= ctrl;
    end
  end

endmodule

FILE: design/cau_final.sv
// Output stage: quotient rounding and saturation, root clipping, result
// select per opcode; holds the output register. Depends on cau_pkg.
module cau_final import cau_pkg::*; #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] rem_re,
  input  logic [2*W-1:0] rem_im,
  input  logic [W-1:0]   q_re,
  input  logic [W-1:0]   q_im,
  input  logic           ovf_re,
  input  logic           ovf_im,
  input  logic           neg_re,
  input  logic           neg_im,
  input  logic [W-1:0]   sroot,
  input  logic [W-1:0]   pre_re,
  input  logic [W-1:0]   pre_im,
  input  ctrl_t          ctrl,
  output logic [W-1:0]   res_re_r,
  output logic [W-1:0]   res_im_r,
  output logic           div_zero_r,
  output logic           sat_r
);

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]   LIM  = {2'b01, {(W-1){1'b0}}};

  // returns {clipped, value}
  function automatic logic [W:0] div_part(input logic [W-1:0] q, input logic rnz,
                                          input logic neg, input logic ovf);
    logic [W:0]   mag;
    logic [W-1:0] val;
    logic         clip;
    mag  = {1'b0, q} + {{W{1'b0}}, (neg && rnz)};
    clip = 1'b0;
    val  = q;
    if (neg) begin
      if (ovf || mag > LIM) begin
        val  = MINV;
        clip = 1'b1;
      end else begin
        val = '0 - mag[W-1:0];
      end
    end else if (ovf || q[W-1]) begin
      val  = MAXV;
      clip = 1'b1;
    end
    return {clip, val};
  endfunction

  logic [W:0]   dr, di;
  logic [W-1:0] re_nxt, im_nxt;
  logic         dz_nxt, sat_nxt;

  assign dr = div_part(q_re, rem_re != '0, neg_re, ovf_re);
  assign di = div_part(q_im, rem_im != '0, neg_im, ovf_im);

  always_comb begin
    re_nxt  = pre_re;
    im_nxt  = pre_im;
    dz_nxt  = 1'b0;
    sat_nxt = ctrl.sat;
    unique case (ctrl.op)
      OP_DIV: begin
        if (ctrl.div_zero) begin
          re_nxt  = '0;
          im_nxt  = '0;
          dz_nxt  = 1'b1;
          sat_nxt = 1'b0;
        end else begin
          re_nxt  = dr[W-1:0];
          im_nxt  = di[W-1:0];
          sat_nxt = dr[W] || di[W];
        end
      end
      OP_MAG: begin
        re_nxt  = sroot[W-1] ? MAXV : sroot;
        im_nxt  = '0;
        sat_nxt = sroot[W-1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r   <= re_nxt;
      res_im_r   <= im_nxt;
      div_zero_r <= dz_nxt;
      sat_r      <= sat_nxt;
    end
  end

endmodule

FILE: design/complex_arithmetic_unit.sv
// Complex arithmetic unit: top level of a fully pipelined complex ALU.
// Depends on cau_pkg, cau_if and the cau_* stage modules.
//
// Takes one transaction per clock unless the output stalls, and returns one
// result per transaction, in order. Every opcode passes through the same
// stages: a product stage, a sum stage, a normalize stage, one stage
// per quotient/root bit (DATA_WIDTH stages, each one compare-subtract wide
// as the product sum), and the output register. Throughput is one
// transaction per cycle unless the output stalls, as the chain is pipelined.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so bubbles close up during an output stall and inputs
// keep flowing until the pipe is full. Operands are signed fixed point with
// FRAC_BITS fraction bits; products, quotients and roots round toward minus
// infinity, results clip to the signed range with the saturated flag, and a
// divide by 0+0i returns 0+0i with div_zero set. Opcodes 5..7 return zero.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  cau_in_if.sink      in_ch,
  cau_out_if.source   out_ch
);

  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int L = W + 4;   // pipeline depth

  // ---- stage valids and advance chain ----
  logic [L-1:0] v_r;
  logic [L-1:0] v_in;
  logic [L:0]   adv;

  assign adv[L] = out_ch.ready;
  for (genvar k = 0; k < L; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end
  assign v_in = {v_r[L-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < L; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign in_ch.ready  = adv[0];
  assign out_ch.valid = v_r[L-1];

  // ---- stage 1: products ----
  logic signed [2*W-1:0] p0, p1, p2, p3, p4, p5;
  logic [W-1:0]          s1_re, s1_im;
  ctrl_t                 s1_ctrl;

  cau_mult #(.W(W)) u_mult (
    .clk(clk), .en(adv[0]), .opcode(in_ch.opcode),
    .a_re(in_ch.a_re), .a_im(in_ch.a_im), .b_re(in_ch.b_re), .b_im(in_ch.b_im),
    .p0_r(p0), .p1_r(p1), .p2_r(p2), .p3_r(p3), .p4_r(p4), .p5_r(p5),
    .pre_re_r(s1_re), .pre_im_r(s1_im), .ctrl_r(s1_ctrl)
  );

  // ---- stage 2: sums ----
  logic signed [2*W:0] n_re, n_im;
  logic [2*W-1:0]      s2_d;
  logic [W-1:0]        s2_re, s2_im;
  ctrl_t               s2_ctrl;

  cau_sum #(.W(W), .F(F)) u_sum (
    .clk(clk), .en(adv[1]),
    .p0(p0), .p1(p1), .p2(p2), .p3(p3), .p4(p4), .p5(p5),
    .pre_re(s1_re), .pre_im(s1_im), .ctrl(s1_ctrl),
    .n_re_r(n_re), .n_im_r(n_im), .d_r(s2_d),
    .pre_re_r(s2_re), .pre_im_r(s2_im), .ctrl_r(s2_ctrl)
  );

  // ---- stage 3 feeds the bit-step chain, index 0 ----
  logic [2*W-1:0] rem_re_s  [0:W];
  logic [2*W-1:0] rem_im_s  [0:W];
  logic [W-1:0]   q_re_s    [0:W];
  logic [W-1:0]   q_im_s    [0:W];
  logic           ovf_re_s  [0:W];
  logic           ovf_im_s  [0:W];
  logic [2*W-1:0] nmag_re_s [0:W];
  logic [2*W-1:0] nmag_im_s [0:W];
  logic           neg_re_s  [0:W];
  logic           neg_im_s  [0:W];
  logic [2*W-1:0] d_s       [0:W];
  logic [W+1:0]   srem_s    [0:W];
  logic [W-1:0]   sroot_s   [0:W];
  logic [W-1:0]   pre_re_s  [0:W];
  logic [W-1:0]   pre_im_s  [0:W];
  ctrl_t          ctrl_s    [0:W];

  cau_norm #(.W(W), .F(F)) u_norm (
    .clk(clk), .en(adv[2]),
    .n_re(n_re), .n_im(n_im), .d(s2_d),
    .pre_re(s2_re), .pre_im(s2_im), .ctrl(s2_ctrl),
    .rem_re_r(rem_re_s[0]), .rem_im_r(rem_im_s[0]),
    .nmag_re_r(nmag_re_s[0]), .nmag_im_r(nmag_im_s[0]),
    .neg_re_r(neg_re_s[0]), .neg_im_r(neg_im_s[0]),
    .d_r(d_s[0]), .pre_re_r(pre_re_s[0]), .pre_im_r(pre_im_s[0]),
    .ctrl_r(ctrl_s[0])
  );

  // quotient, root and overflow start empty
  assign q_re_s[0]   = '0;
  assign q_im_s[0]   = '0;
  assign ovf_re_s[0] = 1'b0;
  assign ovf_im_s[0] = 1'b0;
  assign srem_s[0]   = '0;
  assign sroot_s[0]  = '0;

  // ---- bit steps: MSB first ----
  for (genvar j = 0; j < W; j++) begin : g_step
    cau_step #(.W(W), .F(F), .K(W - 1 - j)) u_step (
      .clk(clk), .en(adv[3+j]),
      .rem_re(rem_re_s[j]), .rem_im(rem_im_s[j]),
      .q_re(q_re_s[j]), .q_im(q_im_s[j]),
      .ovf_re(ovf_re_s[j]), .ovf_im(ovf_im_s[j]),
      .nmag_re(nmag_re_s[j]), .nmag_im(nmag_im_s[j]),
      .neg_re(neg_re_s[j]), .neg_im(neg_im_s[j]),
      .d(d_s[j]), .srem(srem_s[j]), .sroot(sroot_s[j]),
      .pre_re(pre_re_s[j]), .pre_im(pre_im_s[j]), .ctrl(ctrl_s[j]),
      .rem_re_r(rem_re_s[j+1]), .rem_im_r(rem_im_s[j+1]),
      .q_re_r(q_re_s[j+1]), .q_im_r(q_im_s[j+1]),
      .ovf_re_r(ovf_re_s[j+1]), .ovf_im_r(ovf_im_s[j+1]),
      .nmag_re_r(nmag_re_s[j+1]), .nmag_im_r(nmag_im_s[j+1]),
      .neg_re_r(neg_re_s[j+1]), .neg_im_r(neg_im_s[j+1]),
      .d_r(d_s[j+1]), .srem_r(srem_s[j+1]), .sroot_r(sroot_s[j+1]),
      .pre_re_r(pre_re_s[j+1]), .pre_im_r(pre_im_s[j+1]), .ctrl_r(ctrl_s[j+1])
    );
  end

  // ---- output register ----
  logic [W-1:0] res_re, res_im;
  logic         res_dz, res_sat;

  cau_final #(.W(W)) u_final (
    .clk(clk), .en(adv[W+3]),
    .rem_re(rem_re_s[W]), .rem_im(rem_im_s[W]),
    .q_re(q_re_s[W]), .q_im(q_im_s[W]),
    .ovf_re(ovf_re_s[W]), .ovf_im(ovf_im_s[W]),
    .neg_re(neg_re_s[W]), .neg_im(neg_im_s[W]),
    .sroot(sroot_s[W]), .pre_re(pre_re_s[W]), .pre_im(pre_im_s[W]),
    .ctrl(ctrl_s[W]),
    .res_re_r(res_re), .res_im_r(res_im), .div_zero_r(res_dz), .sat_r(res_sat)
  );

  assign out_ch.res_re    = res_re;
  assign out_ch.res_im    = res_im;
  assign out_ch.div_zero  = res_dz;
  assign out_ch.saturated = res_sat;

  // ---- assertions ----
  // a zero-divisor result is exactly 0+0i with no clip
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.div_zero) |->
      (out_ch.res_re == '0 && out_ch.res_im == '0 && !out_ch.saturated))
    else $error("div_zero result not forced to zero");

  // with the output register empty the whole pipe must be able to move
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output stage empty");

  // a stalled, full pipe takes nothing
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted into full stalled pipe");

endmodule
